@@ sv/smac_pkg.sv @@
`default_nettype none
package smac_pkg;

  // Shadow window geometry.
  localparam int ShadowChunks = 4096;
  localparam int ChunkBits    = $clog2(ShadowChunks);
  localparam int IdxW         = ChunkBits + 1;
  localparam int RangeW       = 35;

  // Poison codes that have a named class.
  localparam logic [7:0] CodeHeap   = 8'hFA;
  localparam logic [7:0] CodeStack  = 8'hF1;
  localparam logic [7:0] CodeGlobal = 8'hF9;
  localparam logic [7:0] CodeFreed  = 8'hFD;

  // Result kinds.
  localparam logic [2:0] KindOk     = 3'd0;
  localparam logic [2:0] KindHeap   = 3'd1;
  localparam logic [2:0] KindFreed  = 3'd2;
  localparam logic [2:0] KindStack  = 3'd3;
  localparam logic [2:0] KindGlobal = 3'd4;
  localparam logic [2:0] KindOther  = 3'd5;

  // Input actions.
  localparam logic [1:0] ActCheck = 2'd0;
  localparam logic [1:0] ActFill  = 2'd1;
  localparam logic [1:0] ActGuard = 2'd2;

  localparam logic [6:0] GuardReset = 7'd16;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_CHECK,
    CMD_FILL
  } cmd_op_e;

  // One command for the back end. For a check, lo and hi hold the chunk
  // indexes of the first and last byte.
  typedef struct packed {
    cmd_op_e          op;
    logic [IdxW-1:0]  lo;
    logic [IdxW-1:0]  hi;
    logic             in_a;
    logic             in_b;
    logic [2:0]       off_a;
    logic [2:0]       off_b;
    logic [7:0]       val;
    logic             wr;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
  } range_t;

  typedef enum logic [2:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_RD_A,
    BE_RD_B,
    BE_EVAL,
    BE_FILL,
    BE_DONE
  } be_state_e;

  // Chunk range that overlaps bytes [start, stop), clipped to the window.
  function automatic range_t fill_range(logic [RangeW-1:0] start,
                                        logic [RangeW-1:0] stop);
    logic [RangeW-1:0] lo_w;
    logic [RangeW-1:0] hi_w;
    logic [RangeW-1:0] lim;
    range_t r;
    lim  = RangeW'(ShadowChunks);
    lo_w = start >> 3;
    hi_w = (stop + RangeW'(7)) >> 3;
    if (lo_w > lim) lo_w = lim;
    if (hi_w > lim) hi_w = lim;
    r.lo = lo_w[IdxW-1:0];
    r.hi = hi_w[IdxW-1:0];
    r.ok = (stop > start) && (lo_w < hi_w);
    return r;
  endfunction

  function automatic logic poisoned(logic [7:0] sv, logic [2:0] off);
    return (sv != 8'd0) && (sv[7] || ({5'd0, off} >= sv));
  endfunction

  function automatic logic [2:0] classify(logic [7:0] code);
    logic [2:0] k;
    unique case (code)
      CodeHeap:   k = KindHeap;
      CodeFreed:  k = KindFreed;
      CodeStack:  k = KindStack;
      CodeGlobal: k = KindGlobal;
      default:    k = KindOther;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ sv/smac_ram.sv @@
`default_nettype none
module smac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/smac_front.sv @@
`default_nettype none
module smac_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [31:0]       address_i,
  input  wire logic [31:0]       length_i,
  input  wire logic              access_wr_i,
  input  wire logic [7:0]        shadow_code_i,
  input  wire logic              left_guard_i,
  input  wire logic              clearing_i,
  output logic                   cmd_valid_o,
  output smac_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_pop_i
);

  logic [6:0]     guard_q;
  logic [1:0]     step_q, step_d;
  smac_pkg::cmd_t cmd;
  smac_pkg::cmd_t fifo_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push, full;

  // Guard length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= smac_pkg::GuardReset;
    end else if (cfg_we_i) begin
      guard_q <= cfg_wdata_i;
    end
  end

  // Decode the held transaction into the command for the current step.
  always_comb begin
    logic [smac_pkg::RangeW-1:0] addr_w, len_w, g_w, uend, aligned, base, tail;
    logic [31:0]                 last_b;
    logic [28:0]                 ca, cb;
    smac_pkg::range_t            r;
    addr_w  = smac_pkg::RangeW'(address_i);
    len_w   = smac_pkg::RangeW'(length_i);
    g_w     = smac_pkg::RangeW'(guard_q);
    uend    = addr_w + len_w;
    aligned = smac_pkg::RangeW'({length_i[31:3], 3'b000});
    base    = (addr_w >= g_w) ? addr_w - g_w : '0;
    tail    = addr_w + aligned;
    last_b  = address_i + length_i - 32'd1;
    ca      = address_i[31:3];
    cb      = last_b[31:3];
    r       = '0;
    cmd       = '0;
    cmd.op    = smac_pkg::CMD_NOP;
    cmd.val   = shadow_code_i;
    cmd.wr    = access_wr_i;
    cmd.last  = 1'b1;
    unique case (action_i)
      smac_pkg::ActCheck: begin
        cmd.op    = (length_i == 32'd0) ? smac_pkg::CMD_NOP : smac_pkg::CMD_CHECK;
        cmd.in_a  = ca < 29'(smac_pkg::ShadowChunks);
        cmd.in_b  = cb < 29'(smac_pkg::ShadowChunks);
        cmd.lo    = smac_pkg::IdxW'(ca[smac_pkg::ChunkBits-1:0]);
        cmd.hi    = smac_pkg::IdxW'(cb[smac_pkg::ChunkBits-1:0]);
        cmd.off_a = address_i[2:0];
        cmd.off_b = last_b[2:0];
      end
      smac_pkg::ActFill: begin
        r = smac_pkg::fill_range(addr_w, uend);
      end
      smac_pkg::ActGuard: begin
        cmd.last = (step_q == 2'd2);
        if (step_q == 2'd0) begin
          r = left_guard_i ? smac_pkg::fill_range(base, uend + g_w)
                           : smac_pkg::fill_range(uend, uend + g_w);
        end else if (step_q == 2'd1) begin
          r = smac_pkg::fill_range(addr_w, tail);
          cmd.val = 8'd0;
        end else begin
          // Partial tail chunk records how many leading bytes are valid.
          r = smac_pkg::fill_range(tail, tail + smac_pkg::RangeW'(1));
          r.ok = r.ok && (length_i[2:0] != 3'd0);
          cmd.val = {5'd0, length_i[2:0]};
        end
      end
      default: ;
    endcase
    if (action_i != smac_pkg::ActCheck) begin
      cmd.lo = r.lo;
      cmd.hi = r.hi;
      if (r.ok) cmd.op = smac_pkg::CMD_FILL;
    end
  end

  assign full       = cnt_q[1];
  assign push       = in_valid_i && !clearing_i && !full;
  assign in_stall_o = clearing_i || full || !cmd.last;

  always_comb begin
    step_d = step_q;
    if (push) step_d = cmd.last ? 2'd0 : step_q + 2'd1;
  end

  // Two-entry command queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      step_q <= step_d;
      if (push) wptr_q <= ~wptr_q;
      if (cmd_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= cmd;
  end

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rptr_q];

endmodule
`default_nettype wire

@@ sv/smac_back.sv @@
`default_nettype none
module smac_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  smac_pkg::cmd_t         cmd_i,
  output logic                   cmd_pop_o,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             kind_o,
  output logic [7:0]             fault_code_o,
  output logic                   write_access_o
);

  smac_pkg::be_state_e          state_q, state_d;
  logic [smac_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [7:0]                   s1_q, s1_d;
  logic [2:0]                   kind_q, kind_d;
  logic [7:0]                   code_q, code_d;
  logic                         wr_q, wr_d;
  logic                         out_valid_q, out_valid_d;
  logic [2:0]                   okind_q;
  logic [7:0]                   ocode_q;
  logic                         owr_q;
  logic                         load_out;
  logic                         we;
  logic [smac_pkg::ChunkBits-1:0] waddr, raddr;
  logic [7:0]                   wdata, rdata;

  smac_ram #(
    .Width (8),
    .Depth (smac_pkg::ShadowChunks)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer for the clearing pass, checks and chunk walks.
  always_comb begin
    logic [7:0] s2;
    logic [7:0] found;
    state_d   = state_q;
    idx_d     = idx_q;
    s1_d      = s1_q;
    kind_d    = kind_q;
    code_d    = code_q;
    wr_d      = wr_q;
    we        = 1'b0;
    waddr     = idx_q[smac_pkg::ChunkBits-1:0];
    wdata     = cmd_i.val;
    raddr     = cmd_i.lo[smac_pkg::ChunkBits-1:0];
    cmd_pop_o = 1'b0;
    load_out  = 1'b0;
    s2        = cmd_i.in_b ? rdata : 8'd0;
    found     = 8'd0;
    unique case (state_q)
      smac_pkg::BE_CLEAR: begin
        we    = 1'b1;
        wdata = 8'd0;
        idx_d = idx_q + 1'b1;
        if (idx_q == smac_pkg::IdxW'(smac_pkg::ShadowChunks - 1)) begin
          state_d = smac_pkg::BE_IDLE;
        end
      end
      smac_pkg::BE_IDLE: begin
        kind_d = smac_pkg::KindOk;
        code_d = 8'd0;
        wr_d   = 1'b0;
        idx_d  = cmd_i.lo;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            smac_pkg::CMD_CHECK: state_d = smac_pkg::BE_RD_A;
            smac_pkg::CMD_FILL:  state_d = smac_pkg::BE_FILL;
            default:             state_d = smac_pkg::BE_DONE;
          endcase
        end
      end
      // The first byte's chunk is on the read port; request the last byte's.
      smac_pkg::BE_RD_A: begin
        s1_d    = cmd_i.in_a ? rdata : 8'd0;
        raddr   = cmd_i.hi[smac_pkg::ChunkBits-1:0];
        state_d = smac_pkg::BE_RD_B;
      end
      // Hold the last byte's address so its chunk is read out for evaluation.
      smac_pkg::BE_RD_B: begin
        raddr   = cmd_i.hi[smac_pkg::ChunkBits-1:0];
        state_d = smac_pkg::BE_EVAL;
      end
      smac_pkg::BE_EVAL: begin
        found = s1_q[7] ? s1_q : (s2[7] ? s2 : 8'd0);
        if (smac_pkg::poisoned(s1_q, cmd_i.off_a) || smac_pkg::poisoned(s2, cmd_i.off_b)) begin
          kind_d = smac_pkg::classify(found);
          code_d = found;
          wr_d   = cmd_i.wr;
        end
        state_d = smac_pkg::BE_DONE;
      end
      smac_pkg::BE_FILL: begin
        we    = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_d == cmd_i.hi) state_d = smac_pkg::BE_DONE;
      end
      smac_pkg::BE_DONE: begin
        if (!cmd_i.last) begin
          cmd_pop_o = 1'b1;
          state_d   = smac_pkg::BE_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          cmd_pop_o = 1'b1;
          load_out  = 1'b1;
          state_d   = smac_pkg::BE_IDLE;
        end
      end
      default: state_d = smac_pkg::BE_IDLE;
    endcase
  end

  // Output register parts the back end from the result channel.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smac_pkg::BE_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= s1_d;
    kind_q <= kind_d;
    code_q <= code_d;
    wr_q   <= wr_d;
    if (load_out) begin
      okind_q <= kind_q;
      ocode_q <= code_q;
      owr_q   <= wr_q;
    end
  end

  assign clearing_o     = state_q == smac_pkg::BE_CLEAR;
  assign out_valid_o    = out_valid_q;
  assign kind_o         = okind_q;
  assign fault_code_o   = ocode_q;
  assign write_access_o = owr_q;

  // A chunk walk never writes at or past the end of its range.
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smac_pkg::BE_FILL |-> idx_q < cmd_i.hi)
    else $error("fill walk left its range");

  // No command is retired during the clearing pass.
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smac_pkg::BE_CLEAR |-> !cmd_pop_o)
    else $error("command retired while clearing");

  // A result is only loaded when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // A check always passes through evaluation before it retires.
  a_check_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smac_pkg::BE_RD_B |=> state_q == smac_pkg::BE_EVAL)
    else $error("check skipped evaluation");

endmodule
`default_nettype wire

@@ sv/shadow_memory_access_checker.sv @@
// Channel   Handshake               Payload
// in        in_valid_i/in_stall_o   action, address, length, access_wr, shadow_code, left_guard
// out       out_valid_o/out_stall_i kind, fault_code, write_access
// cfg       cfg_we_i                cfg_wdata_i (guard length)
//
// A check takes the back end through dispatch, two reads of the single-read-port
// shadow RAM, evaluation and retire. A fill takes it through dispatch, one write
// per chunk and retire; a guard queues three such commands, one per cycle while
// the queue has room, and in_stall_o stays high until the last is queued.
// After reset a clearing pass writes zero to all 4096 chunks with the input
// stalled; a stalled result holds the back end in its retire state.
`default_nettype none
module shadow_memory_access_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] length_i,
  input  wire logic        access_wr_i,
  input  wire logic [7:0]  shadow_code_i,
  input  wire logic        left_guard_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       fault_code_o,
  output logic             write_access_o
);

  logic           cmd_valid, cmd_pop, clearing;
  smac_pkg::cmd_t cmd;

  smac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .address_i     (address_i),
    .length_i      (length_i),
    .access_wr_i   (access_wr_i),
    .shadow_code_i (shadow_code_i),
    .left_guard_i  (left_guard_i),
    .clearing_i    (clearing),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  smac_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .fault_code_o   (fault_code_o),
    .write_access_o (write_access_o)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smac_pkg::*;

  localparam int WindowBytes = ShadowChunks * 8;

  // Expected verdict for one transaction of any action.
  typedef struct {
    logic [2:0] kind;
    logic [7:0] fault;
    logic       wr;
  } verdict_t;

  // Tracks the shadow store and the guard length, and predicts the verdict of
  // every accepted transaction.
  class access_verdict_board;
    logic [7:0] shadow_mem [ShadowChunks];
    logic [6:0] guard_len;
    verdict_t   expected_verdicts [$];
    int         mismatches;

    function void clear_all();
      foreach (shadow_mem[i]) shadow_mem[i] = 8'd0;
      guard_len = GuardReset;
      mismatches = 0;
    endfunction

    function logic [7:0] peek_chunk(longint unsigned addr);
      longint unsigned idx;
      idx = addr >> 3;
      if (idx >= ShadowChunks) return 8'd0;
      return shadow_mem[idx];
    endfunction

    function void poke_chunk(longint unsigned addr, logic [7:0] v);
      longint unsigned idx;
      idx = addr >> 3;
      if (idx < ShadowChunks) shadow_mem[idx] = v;
    endfunction

    // Writes v to every chunk that overlaps bytes [start, stop).
    function void paint_range(longint unsigned start, longint unsigned stop,
                              logic [7:0] v);
      longint unsigned lo;
      longint unsigned hi;
      if (stop <= start) return;
      lo = start >> 3;
      hi = (stop + 7) >> 3;
      if (hi > ShadowChunks) hi = ShadowChunks;
      for (longint unsigned i = lo; i < hi; i++) shadow_mem[i] = v;
    endfunction

    function bit addr_flagged(longint unsigned addr);
      logic [7:0] sv;
      sv = peek_chunk(addr);
      if (sv == 8'd0) return 0;
      if (sv[7]) return 1;
      return (addr & 7) >= sv;
    endfunction

    function logic [2:0] kind_of(logic [7:0] code);
      case (code)
        CodeHeap:   return KindHeap;
        CodeFreed:  return KindFreed;
        CodeStack:  return KindStack;
        CodeGlobal: return KindGlobal;
        default:    return KindOther;
      endcase
    endfunction

    // Applies one accepted transaction and queues its expected verdict.
    function void note_item(logic [1:0] act, logic [31:0] addr, logic [31:0] len,
                            logic wr, logic [7:0] code, logic left);
      verdict_t v;
      logic [31:0] last;
      logic [7:0] s1;
      logic [7:0] s2;
      longint unsigned a;
      longint unsigned user_end;
      longint unsigned aligned;
      longint unsigned g;
      longint unsigned base;
      v.kind = KindOk;
      v.fault = 8'd0;
      v.wr = 1'b0;
      a = addr;
      g = guard_len;
      if (act == ActCheck) begin
        if (len != 0) begin
          last = addr + len - 32'd1;
          if (addr_flagged(a) || addr_flagged(last)) begin
            s1 = peek_chunk(a);
            s2 = peek_chunk(last);
            v.fault = s1[7] ? s1 : (s2[7] ? s2 : 8'd0);
            v.kind = kind_of(v.fault);
            v.wr = wr;
          end
        end
      end else if (act == ActFill) begin
        paint_range(a, a + len, code);
      end else if (act == ActGuard) begin
        user_end = a + len;
        aligned = len & ~32'd7;
        if (left) begin
          base = (a >= g) ? a - g : 0;
          paint_range(base, user_end + g, code);
        end else begin
          paint_range(user_end, user_end + g, code);
        end
        paint_range(a, a + aligned, 8'd0);
        if (len[2:0] != 3'd0) poke_chunk(a + aligned, {5'd0, len[2:0]});
      end
      expected_verdicts.push_back(v);
    endfunction

    // Compares one accepted result with the oldest expected verdict.
    function void check_result(logic [2:0] kind, logic [7:0] fault, logic wr);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d fault=%h wr=%0d", kind, fault, wr);
        return;
      end
      v = expected_verdicts.pop_front();
      if (kind !== v.kind || fault !== v.fault || wr !== v.wr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected kind=%0d fault=%h wr=%0d, got kind=%0d fault=%h wr=%0d",
                   v.kind, v.fault, v.wr, kind, fault, wr);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = 7'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ActCheck;
  logic [31:0] address_i = 32'd0;
  logic [31:0] length_i = 32'd0;
  logic        access_wr_i = 1'b0;
  logic [7:0]  shadow_code_i = 8'd0;
  logic        left_guard_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [2:0]  kind_o;
  logic [7:0]  fault_code_o;
  logic        write_access_o;

  access_verdict_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always #1 clk_i = ~clk_i;

  shadow_memory_access_checker u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .action_i, .address_i, .length_i, .access_wr_i, .shadow_code_i, .left_guard_i,
    .out_valid_o, .out_stall_i, .kind_o, .fault_code_o, .write_access_o
  );

  // Result side: check accepted results, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(kind_o, fault_code_o, write_access_o);
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offers one transaction and waits until it is accepted.
  task automatic send_item(logic [1:0] act, logic [31:0] addr, logic [31:0] len,
                           logic wr, logic [7:0] code, logic left);
    in_valid_i <= 1'b1;
    action_i <= act;
    address_i <= addr;
    length_i <= len;
    access_wr_i <= wr;
    shadow_code_i <= code;
    left_guard_i <= left;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(act, addr, len, wr, code, left);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Waits until every expected verdict has arrived, plus some settling time.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_guard(logic [6:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.guard_len = v;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0: return CodeHeap;
      1: return CodeStack;
      2: return CodeGlobal;
      3: return CodeFreed;
      4: return 8'($urandom_range(1, 7));
      5: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      2: return WindowBytes - $urandom_range(0, 64);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 99))
      0: return $urandom;
      1, 2: return $urandom_range(0, 1024);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Mostly a guarded region followed by probes around it, the rest loose items.
  task automatic run_random(int count);
    int sent;
    logic [31:0] base;
    logic [31:0] len;
    logic [1:0] act;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 40) begin
        base = $urandom_range(0, 4000);
        len = $urandom_range(0, 40);
        send_item(ActGuard, base, len, 1'b0, pick_code(), 1'($urandom));
        sent++;
        repeat ($urandom_range(2, 6)) begin
          send_item(ActCheck, base - 32'd72 + $urandom_range(0, 144),
                    $urandom_range(1, 16), 1'($urandom), 8'($urandom), 1'($urandom));
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(ActFill, base, len, 1'b0, CodeFreed, 1'b0);
          sent++;
        end
      end else begin
        act = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_item(act, pick_addr(), pick_len(), 1'($urandom), pick_code(), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    board.clear_all();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_guard(7'd16);

    // Directed cases: each poison class, partial chunks, wrap and clipping.
    send_item(ActCheck, 32'd0, 32'd0, 1'b1, 8'hFF, 1'b1);
    send_item(ActGuard, 32'd64, 32'd13, 1'b0, CodeHeap, 1'b1);
    send_item(ActCheck, 32'd64, 32'd13, 1'b1, 8'd0, 1'b0);
    send_item(ActCheck, 32'd64, 32'd14, 1'b1, 8'd0, 1'b0);
    send_item(ActCheck, 32'd60, 32'd4, 1'b0, 8'd0, 1'b0);
    send_item(ActCheck, 32'd77, 32'd1, 1'b1, 8'd0, 1'b0);
    send_item(ActFill, 32'd200, 32'd8, 1'b0, CodeStack, 1'b0);
    send_item(ActCheck, 32'd196, 32'd8, 1'b0, 8'd0, 1'b0);
    send_item(ActFill, 32'd300, 32'd1, 1'b0, CodeGlobal, 1'b0);
    send_item(ActCheck, 32'd300, 32'd1, 1'b1, 8'd0, 1'b0);
    send_item(ActFill, 32'd400, 32'd0, 1'b0, CodeFreed, 1'b0);
    send_item(ActFill, 32'd408, 32'd9, 1'b0, CodeFreed, 1'b0);
    send_item(ActCheck, 32'd400, 32'd16, 1'b1, 8'd0, 1'b0);
    send_item(ActGuard, 32'd4, 32'd3, 1'b0, 8'h80, 1'b1);
    send_item(ActCheck, 32'd0, 32'd8, 1'b0, 8'd0, 1'b0);
    send_item(ActGuard, 32'd500, 32'd16, 1'b0, 8'h7F, 1'b0);
    send_item(ActCheck, 32'd516, 32'd1, 1'b1, 8'd0, 1'b0);
    send_item(ActCheck, 32'hFFFF_FFF0, 32'd32, 1'b1, 8'd0, 1'b0);
    send_item(ActCheck, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0);
    send_item(ActFill, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, CodeHeap, 1'b0);
    send_item(ActFill, WindowBytes - 8, 32'd64, 1'b0, CodeHeap, 1'b0);
    send_item(ActCheck, WindowBytes - 4, 32'd8, 1'b0, 8'd0, 1'b0);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);
    send_item(ActGuard, 32'd0, 32'hFFFF_FFFF, 1'b1, CodeHeap, 1'b1);
    send_item(ActCheck, 32'd1000, 32'd8, 1'b0, 8'd0, 1'b0);
    drain();

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 19;
    recv_idle_pct = 46;
    write_guard(7'd8);
    run_random(250);
    hold_requests++;
    run_random(250);
    drain();
    write_guard(7'd64);
    run_random(250);
    send_item(ActGuard, 32'd40, 32'd5, 1'b0, CodeStack, 1'b1);
    drain();
    send_item(ActCheck, 32'd0, 32'd8, 1'b1, 8'd0, 1'b0);
    drain();

    // Phase two: the other way round, with odd guard lengths.
    send_idle_pct = 46;
    recv_idle_pct = 19;
    write_guard(7'd0);
    run_random(150);
    drain();
    write_guard(7'd127);
    run_random(150);
    hold_requests++;
    run_random(100);
    drain();

    // Phase three: full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_guard(7'd5);
    run_random(150);
    drain();
    write_guard(7'd16);
    run_random(300);
    drain();
    repeat (50) @(posedge clk_i);

    if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
sv/smac_pkg.sv
sv/smac_ram.sv
sv/smac_front.sv
sv/smac_back.sv
sv/shadow_memory_access_checker.sv
tb/tb.sv
